// ----- src/isort_pkg.sv -----
// Shared types and constants of the insertion sorter.
package isort_pkg;

  localparam int MaxItems   = 32;
  localparam int ValueWidth = 32;

  typedef logic signed [ValueWidth-1:0] value_t;

  typedef enum logic {
    StFill,
    StDrain
  } state_e;

  // Word broadcast from the controller to every cell.
  typedef struct packed {
    logic   insert;
    logic   shift;
    value_t value;
  } cell_ctrl_t;

  // What a cell shows to its neighbors.
  typedef struct packed {
    logic   valid;
    logic   ins;
    value_t value;
  } cell_link_t;

endpackage

// ----- src/isort_if.sv -----
// Valid/ready channel interfaces for the insertion sorter.
interface isort_in_if;
  logic                 valid;
  logic                 ready;
  isort_pkg::value_t    value;
  logic                 last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface isort_out_if;
  logic                 valid;
  logic                 ready;
  isort_pkg::value_t    sorted_value;
  logic                 last_result;
  logic                 overflow;

  modport source (output valid, output sorted_value, output last_result, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_result, input overflow,
                  output ready);
endinterface

// ----- src/isort_cell.sv -----
// One storage cell of the sorting chain.
module isort_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  isort_pkg::cell_ctrl_t ctrl_i,
  input  isort_pkg::cell_link_t left_i,
  input  isort_pkg::cell_link_t right_i,
  output isort_pkg::cell_link_t link_o
);

  logic              valid_q, valid_d;
  isort_pkg::value_t value_q, value_d;
  logic              ins;

  assign ins = !valid_q || (value_q > ctrl_i.value);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.insert) begin
      valid_d = valid_q || left_i.valid;
      if (left_i.ins) begin
        value_d = left_i.value;
      end else if (ins) begin
        value_d = ctrl_i.value;
      end
    end else if (ctrl_i.shift) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.ins   = ins;
  assign link_o.value = value_q;

endmodule

// ----- src/insertion_sorter.sv -----
// Insertion sorter top level: chain of sorting cells and its controller.
//
// Input channel in_i carries a signed 32-bit value and a last_item flag.
// While a set is being collected, one word is accepted every cycle; each
// value is broadcast to the chain of MAX_ITEMS cells and written into its
// sorted place, larger entries moving up one cell. Equal values keep arrival
// order. Once the chain is full, further values are dropped and the overflow
// flag is raised for the whole set.
// A word with last_item set closes the set: in_i.ready drops and the chain
// empties through cell 0 onto out_o, smallest value first, one word per
// cycle while out_o.ready is high, last_result on the final one. The first
// result is offered in the cycle after the last input is accepted; once the
// final result is taken, in_i.ready rises again with an empty chain.
// A stall on out_o freezes the chain; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties the chain, clears the overflow
// flag and leaves the block ready for a new set.
module insertion_sorter #(
  parameter int MAX_ITEMS = isort_pkg::MaxItems
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  isort_in_if.sink      in_i,
  isort_out_if.source   out_o
);

  isort_pkg::state_e     state_q, state_d;
  logic                  overflow_q, overflow_d;
  isort_pkg::cell_ctrl_t ctrl;
  isort_pkg::cell_link_t links [MAX_ITEMS];
  isort_pkg::cell_link_t left_edge, right_edge;
  logic                  in_fire, out_fire, full;

  assign full     = links[MAX_ITEMS-1].valid;
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  assign ctrl.insert = in_fire && !full;
  assign ctrl.shift  = out_fire;
  assign ctrl.value  = in_i.value;

  assign left_edge.valid  = 1'b1;
  assign left_edge.ins    = 1'b0;
  assign left_edge.value  = '0;
  assign right_edge.valid = 1'b0;
  assign right_edge.ins   = 1'b1;
  assign right_edge.value = '0;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    isort_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  ((i == 0) ? left_edge : links[(i == 0) ? 0 : i-1]),
      .right_i ((i == MAX_ITEMS-1) ? right_edge : links[(i == MAX_ITEMS-1) ? i : i+1]),
      .link_o  (links[i])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      isort_pkg::StFill: begin
        if (in_fire && in_i.last_item) begin
          state_d = isort_pkg::StDrain;
        end
      end
      isort_pkg::StDrain: begin
        if (out_fire && out_o.last_result) begin
          state_d = isort_pkg::StFill;
        end
      end
      default: state_d = isort_pkg::StFill;
    endcase
  end

  always_comb begin
    in_i.ready         = 1'b0;
    out_o.valid        = 1'b0;
    out_o.sorted_value = links[0].value;
    out_o.last_result  = !links[1].valid;
    out_o.overflow     = overflow_q;
    case (state_q)
      isort_pkg::StFill:  in_i.ready  = 1'b1;
      isort_pkg::StDrain: out_o.valid = 1'b1;
      default:            in_i.ready  = 1'b0;
    endcase
  end

  always_comb begin
    overflow_d = overflow_q;
    if (in_fire && full) begin
      overflow_d = 1'b1;
    end else if (out_fire && out_o.last_result) begin
      overflow_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= isort_pkg::StFill;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
    end
  end

endmodule
